### rtl/tga_dec_pkg.sv
`default_nettype none

package tga_dec_pkg;

   localparam logic [1:0] PHASE_HEADER  = 2'd0;
   localparam logic [1:0] PHASE_SKIP    = 2'd1;
   localparam logic [1:0] PHASE_PIXEL   = 2'd2;
   localparam logic [1:0] PHASE_DISCARD = 2'd3;

   localparam logic [1:0] KIND_HDR_OK    = 2'd0;
   localparam logic [1:0] KIND_PIXEL     = 2'd1;
   localparam logic [1:0] KIND_HDR_BAD   = 2'd2;
   localparam logic [1:0] KIND_TRUNCATED = 2'd3;

   localparam logic [15:0] MAX_SIDE_RESET = 16'd8192;
   localparam logic [4:0]  HDR_LAST_BYTE  = 5'd17;
   localparam logic [7:0]  IMAGE_TYPE_RGB = 8'd2;
   localparam logic [7:0]  DEPTH_24       = 8'd24;
   localparam logic [7:0]  DEPTH_32       = 8'd32;
   localparam logic [7:0]  ALPHA_OPAQUE   = 8'd255;
   localparam logic [7:0]  DESC_TOP_ORIGIN = 8'h20;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] pixel_column;
      logic [15:0] pixel_row;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  alpha;
      logic        last_of_run;
   } rsp_item_type;

endpackage

`default_nettype wire

### rtl/tga_truecolor_stream_decoder.sv
`default_nettype none

// channel  dir  handshake            payload
// req_     in   req_valid/req_stall  data_byte, end_of_stream
// rsp_     out  rsp_valid/rsp_stall  result_kind .. last_of_run
// csr_     in   csr_valid/csr_ready  max_side
//
// One byte per cycle is taken while req_stall is low; parsing state updates in the cycle of acceptance.
// Each byte gives up to two items, written into a four-entry result queue.
// req_stall is raised while fewer than two queue entries are free.
// Synchronous reset clears the parser and queue and sets max_side to 8192.

module tga_truecolor_stream_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   input  wire logic        req_end_of_stream,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic [15:0]      rsp_pixel_column,
   output logic [15:0]      rsp_pixel_row,
   output logic [7:0]       rsp_red,
   output logic [7:0]       rsp_green,
   output logic [7:0]       rsp_blue,
   output logic [7:0]       rsp_alpha,
   output logic             rsp_last_of_run,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_max_side
);

   logic [15:0] max_side_ff;
   logic [1:0]  phase_ff, phase_in;
   logic [4:0]  header_count_ff, header_count_in;
   logic [7:0]  id_length_ff, id_length_in;
   logic        header_bad_ff, header_bad_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic        four_byte_ff, four_byte_in;
   logic        top_origin_ff, top_origin_in;
   logic [7:0]  skip_count_ff, skip_count_in;
   logic [1:0]  byte_in_pixel_ff, byte_in_pixel_in;
   logic [23:0] pixel_bytes_ff, pixel_bytes_in;
   logic [15:0] column_ff, column_in;
   logic [15:0] row_ff, row_in;

   tga_dec_pkg::rsp_item_type fifo_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   tga_dec_pkg::rsp_item_type res0, res1;
   logic [1:0]  n_res;
   logic        req_take, rsp_take;
   logic        bad_now, done;
   logic [1:0]  last_idx;
   logic [15:0] col_next, row_next;
   logic [1:0]  wr_ptr_p1;

   assign csr_ready = 1'b1;
   assign req_stall = (count_ff > 3'd2);
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   always_comb begin
      phase_in         = phase_ff;
      header_count_in  = header_count_ff;
      id_length_in     = id_length_ff;
      header_bad_in    = header_bad_ff;
      width_in         = width_ff;
      height_in        = height_ff;
      four_byte_in     = four_byte_ff;
      top_origin_in    = top_origin_ff;
      skip_count_in    = skip_count_ff;
      byte_in_pixel_in = byte_in_pixel_ff;
      pixel_bytes_in   = pixel_bytes_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      res0             = '0;
      res1             = '0;
      res1.result_kind = tga_dec_pkg::KIND_TRUNCATED;
      res1.last_of_run = 1'b1;
      n_res            = 2'd0;
      bad_now          = 1'b0;
      done             = 1'b0;
      last_idx         = four_byte_ff ? 2'd3 : 2'd2;
      col_next         = column_ff + 16'd1;
      row_next         = row_ff + 16'd1;

      case (phase_ff)
         tga_dec_pkg::PHASE_HEADER: begin
            case (header_count_ff)
               5'd0: id_length_in = req_data_byte;
               5'd1: if (req_data_byte != 8'd0) header_bad_in = 1'b1;
               5'd2: if (req_data_byte != tga_dec_pkg::IMAGE_TYPE_RGB) header_bad_in = 1'b1;
               5'd12: width_in[7:0]   = req_data_byte;
               5'd13: width_in[15:8]  = req_data_byte;
               5'd14: height_in[7:0]  = req_data_byte;
               5'd15: height_in[15:8] = req_data_byte;
               5'd16: begin
                  if (!(req_data_byte inside {tga_dec_pkg::DEPTH_24, tga_dec_pkg::DEPTH_32}))
                     header_bad_in = 1'b1;
                  four_byte_in = (req_data_byte == tga_dec_pkg::DEPTH_32);
               end
               5'd17: top_origin_in = |(req_data_byte & tga_dec_pkg::DESC_TOP_ORIGIN);
               default: ;
            endcase
            if (header_count_ff < tga_dec_pkg::HDR_LAST_BYTE) begin
               header_count_in = header_count_ff + 5'd1;
               if (req_end_of_stream) begin
                  res0  = res1;
                  n_res = 2'd1;
               end
            end else begin
               bad_now = header_bad_ff || (width_ff == 16'd0) || (height_ff == 16'd0)
                         || (width_ff > max_side_ff) || (height_ff > max_side_ff);
               if (bad_now) begin
                  header_bad_in    = 1'b1;
                  res0.result_kind = tga_dec_pkg::KIND_HDR_BAD;
                  res0.last_of_run = 1'b1;
                  n_res            = 2'd1;
                  phase_in         = tga_dec_pkg::PHASE_DISCARD;
               end else begin
                  res0.result_kind  = tga_dec_pkg::KIND_HDR_OK;
                  res0.image_width  = width_ff;
                  res0.image_height = height_ff;
                  res0.last_of_run  = !req_end_of_stream;
                  n_res             = req_end_of_stream ? 2'd2 : 2'd1;
                  byte_in_pixel_in  = 2'd0;
                  pixel_bytes_in    = '0;
                  column_in         = '0;
                  row_in            = '0;
                  skip_count_in     = id_length_ff;
                  phase_in          = (id_length_ff != 8'd0) ? tga_dec_pkg::PHASE_SKIP
                                                             : tga_dec_pkg::PHASE_PIXEL;
               end
            end
         end
         tga_dec_pkg::PHASE_SKIP: begin
            skip_count_in = skip_count_ff - 8'd1;
            if (skip_count_in == 8'd0) phase_in = tga_dec_pkg::PHASE_PIXEL;
            if (req_end_of_stream) begin
               res0  = res1;
               n_res = 2'd1;
            end
         end
         tga_dec_pkg::PHASE_PIXEL: begin
            if (byte_in_pixel_ff < last_idx) begin
               case (byte_in_pixel_ff)
                  2'd0: pixel_bytes_in[7:0]   = pixel_bytes_ff[7:0] | req_data_byte;
                  2'd1: pixel_bytes_in[15:8]  = pixel_bytes_ff[15:8] | req_data_byte;
                  2'd2: pixel_bytes_in[23:16] = pixel_bytes_ff[23:16] | req_data_byte;
                  default: ;
               endcase
               byte_in_pixel_in = byte_in_pixel_ff + 2'd1;
               if (req_end_of_stream) begin
                  res0  = res1;
                  n_res = 2'd1;
               end
            end else begin
               res0.result_kind  = tga_dec_pkg::KIND_PIXEL;
               res0.pixel_column = column_ff;
               res0.pixel_row    = top_origin_ff ? row_ff : (height_ff - 16'd1 - row_ff);
               res0.blue         = pixel_bytes_ff[7:0];
               res0.green        = pixel_bytes_ff[15:8];
               res0.red          = four_byte_ff ? pixel_bytes_ff[23:16] : req_data_byte;
               res0.alpha        = four_byte_ff ? req_data_byte : tga_dec_pkg::ALPHA_OPAQUE;
               byte_in_pixel_in  = 2'd0;
               pixel_bytes_in    = '0;
               column_in         = col_next;
               if (col_next >= width_ff) begin
                  column_in = '0;
                  row_in    = row_next;
                  if (row_next >= height_ff) begin
                     phase_in = tga_dec_pkg::PHASE_DISCARD;
                     done     = 1'b1;
                  end
               end
               res0.last_of_run = !(req_end_of_stream && !done);
               n_res            = (req_end_of_stream && !done) ? 2'd2 : 2'd1;
            end
         end
         default: ;
      endcase

      if (req_end_of_stream) begin
         phase_in         = tga_dec_pkg::PHASE_HEADER;
         header_count_in  = '0;
         id_length_in     = '0;
         header_bad_in    = 1'b0;
         width_in         = '0;
         height_in        = '0;
         four_byte_in     = 1'b0;
         top_origin_in    = 1'b0;
         skip_count_in    = '0;
         byte_in_pixel_in = '0;
         pixel_bytes_in   = '0;
         column_in        = '0;
         row_in           = '0;
      end
   end

   assign wr_ptr_p1 = wr_ptr_ff + 2'd1;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_take) begin
         wr_ptr_in = wr_ptr_ff + n_res;
         count_in  = count_ff + {1'b0, n_res};
      end
      if (rsp_take) begin
         rd_ptr_in = rd_ptr_ff + 2'd1;
         count_in  = count_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && (n_res != 2'd0)) fifo_ff[wr_ptr_ff] <= res0;
      if (req_take && (n_res == 2'd2)) fifo_ff[wr_ptr_p1] <= res1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_side_ff      <= tga_dec_pkg::MAX_SIDE_RESET;
         phase_ff         <= tga_dec_pkg::PHASE_HEADER;
         header_count_ff  <= '0;
         id_length_ff     <= '0;
         header_bad_ff    <= 1'b0;
         width_ff         <= '0;
         height_ff        <= '0;
         four_byte_ff     <= 1'b0;
         top_origin_ff    <= 1'b0;
         skip_count_ff    <= '0;
         byte_in_pixel_ff <= '0;
         pixel_bytes_ff   <= '0;
         column_ff        <= '0;
         row_ff           <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         count_ff         <= '0;
      end else begin
         if (csr_valid && csr_ready) max_side_ff <= csr_max_side;
         if (req_take) begin
            phase_ff         <= phase_in;
            header_count_ff  <= header_count_in;
            id_length_ff     <= id_length_in;
            header_bad_ff    <= header_bad_in;
            width_ff         <= width_in;
            height_ff        <= height_in;
            four_byte_ff     <= four_byte_in;
            top_origin_ff    <= top_origin_in;
            skip_count_ff    <= skip_count_in;
            byte_in_pixel_ff <= byte_in_pixel_in;
            pixel_bytes_ff   <= pixel_bytes_in;
            column_ff        <= column_in;
            row_ff           <= row_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign rsp_result_kind  = fifo_ff[rd_ptr_ff].result_kind;
   assign rsp_image_width  = fifo_ff[rd_ptr_ff].image_width;
   assign rsp_image_height = fifo_ff[rd_ptr_ff].image_height;
   assign rsp_pixel_column = fifo_ff[rd_ptr_ff].pixel_column;
   assign rsp_pixel_row    = fifo_ff[rd_ptr_ff].pixel_row;
   assign rsp_red          = fifo_ff[rd_ptr_ff].red;
   assign rsp_green        = fifo_ff[rd_ptr_ff].green;
   assign rsp_blue         = fifo_ff[rd_ptr_ff].blue;
   assign rsp_alpha        = fifo_ff[rd_ptr_ff].alpha;
   assign rsp_last_of_run  = fifo_ff[rd_ptr_ff].last_of_run;

endmodule

`default_nettype wire
